FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. They compile to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define SMS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define SMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define SMS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/sms_pkg.sv
`default_nettype none

package sms_pkg;

    localparam int COLUMNS    = 16;
    localparam int ROWS       = 4;
    localparam int ROW_PINS   = 4;
    localparam int SNAP_W     = 64;
    localparam int SNAP_IDX_W = $clog2(SNAP_W);
    localparam int QUERY_W    = 8;
    localparam int CNT_W      = $clog2(COLUMNS + 1);

    typedef logic [ROWS-1:0][COLUMNS-1:0] t_rows;

    typedef enum logic [4:0] {
        PH_CLEAR   = 5'b00001,
        PH_DRIVE   = 5'b00010,
        PH_RISE    = 5'b00100,
        PH_SAMPLE  = 5'b01000,
        PH_PUBLISH = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [ROW_PINS-1:0] row_levels;
        logic [QUERY_W-1:0]  query_index;
    } t_in_item;

    typedef struct packed {
        logic              serial_data;
        logic              shift_clock;
        logic              latch_level;
        logic              snapshot_done;
        logic [SNAP_W-1:0] matrix_state;
        logic              queried_switch;
    } t_out_item;

    // Pin levels and the publish flag as they stand after one tick.
    typedef struct packed {
        logic data;
        logic clk;
        logic latch;
        logic done;
    } t_pins;

endpackage

`default_nettype wire

FILE: hw/rtl/switch_matrix_scanner_core.sv
// Registers: a tick item is held in the input register; its result is taken into the
// result register when that register is empty or being read, and is presented from there.
// Throughput: one item per cycle while the output is not stalled; the scan state is updated
// as an item moves from the input register to the result register, so ticks run back to back.
// Reset (synchronous, active low): scan restarts at the clear phase, snapshot is
// all released, data pin low, clock and latch pins high, both registers empty.
`default_nettype none
`include "assert_macros.svh"

module switch_matrix_scanner_core
    import sms_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_item  i_item,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_result
);

    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      s1_adv;
    t_pins     pins;
    t_rows     published;
    t_out_item n_out_item;

    assign s1_adv  = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_adv;

    sms_sequencer u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (s1_adv),
        .i_row_levels (r_s1_item.row_levels),
        .o_pins       (pins),
        .o_published  (published)
    );

    sms_query u_query (
        .i_rows         (published),
        .i_query_index  (r_s1_item.query_index),
        .o_matrix_state (n_out_item.matrix_state),
        .o_queried      (n_out_item.queried_switch)
    );

    assign n_out_item.serial_data   = pins.data;
    assign n_out_item.shift_clock   = pins.clk;
    assign n_out_item.latch_level   = pins.latch;
    assign n_out_item.snapshot_done = pins.done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1_item <= i_item;
        end
        if (s1_adv) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out_item;

    // A publishing tick comes after the clock and latch have both been raised.
    `SMS_ASSERT_SAME(a_done_pins, i_clk, i_rst_n, o_valid && o_result.snapshot_done, o_result.latch_level && o_result.shift_clock)
    // The clock pin is only low while the latch is held low for shifting.
    `SMS_ASSERT_SAME(a_clk_latch, i_clk, i_rst_n, o_valid && !o_result.shift_clock, !o_result.latch_level)
    // A pressed queried switch must show in the snapshot.
    `SMS_ASSERT_SAME(a_query_snap, i_clk, i_rst_n, o_valid && o_result.queried_switch, o_result.matrix_state != '0)
    // A held item in the input register is not dropped while the output stalls.
    `SMS_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !s1_adv, r_s1_valid)

endmodule

`default_nettype wire

FILE: hw/rtl/sms_sequencer.sv
`default_nettype none

module sms_sequencer
    import sms_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_step,
    input  wire logic [ROW_PINS-1:0] i_row_levels,
    output t_pins                    o_pins,
    output t_rows                    o_published
);

    t_phase            r_phase,     n_phase;
    logic [CNT_W-1:0]  r_count,     n_count;
    t_rows             r_acc,       n_acc;
    t_rows             r_published, n_published;
    logic              r_data,      n_data;
    logic              r_clk_pin,   n_clk_pin;
    logic              r_latch,     n_latch;
    logic              n_done;
    logic [ROWS-1:0]   pressed;

    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            // Rows without a pin read as released.
            pressed[r] = (r < ROW_PINS) ? ~i_row_levels[r % ROW_PINS] : 1'b0;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_acc       = r_acc;
        n_published = r_published;
        n_data      = r_data;
        n_clk_pin   = r_clk_pin;
        n_latch     = r_latch;
        n_done      = 1'b0;
        unique case (r_phase)
            PH_CLEAR: begin
                n_acc   = '0;
                n_count = '0;
                n_phase = PH_DRIVE;
            end
            PH_DRIVE: begin
                n_latch   = 1'b0;
                n_data    = (r_count != '0);
                n_clk_pin = 1'b0;
                n_phase   = PH_RISE;
            end
            PH_RISE: begin
                n_clk_pin = 1'b1;
                n_phase   = PH_SAMPLE;
            end
            PH_SAMPLE: begin
                for (int r = 0; r < ROWS; r++) begin
                    n_acc[r][COLUMNS-1] = r_acc[r][COLUMNS-1] | pressed[r];
                end
                // The final sample after the last column stays unshifted.
                if (r_count != CNT_W'(COLUMNS)) begin
                    for (int r = 0; r < ROWS; r++) begin
                        n_acc[r] = n_acc[r] >> 1;
                    end
                    n_count = r_count + CNT_W'(1);
                    n_phase = PH_DRIVE;
                end else begin
                    n_phase = PH_PUBLISH;
                end
                n_latch = 1'b1;
            end
            PH_PUBLISH: begin
                n_published = r_acc;
                n_done      = 1'b1;
                n_phase     = PH_CLEAR;
            end
            default: begin
                n_phase = PH_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_CLEAR;
            r_count     <= '0;
            r_acc       <= '0;
            r_published <= '0;
            r_data      <= 1'b0;
            r_clk_pin   <= 1'b1;
            r_latch     <= 1'b1;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_acc       <= n_acc;
            r_published <= n_published;
            r_data      <= n_data;
            r_clk_pin   <= n_clk_pin;
            r_latch     <= n_latch;
        end
    end

    assign o_pins.data  = n_data;
    assign o_pins.clk   = n_clk_pin;
    assign o_pins.latch = n_latch;
    assign o_pins.done  = n_done;
    assign o_published  = n_published;

endmodule

`default_nettype wire

FILE: hw/rtl/sms_query.sv
`default_nettype none

module sms_query
    import sms_pkg::*;
(
    input  wire t_rows              i_rows,
    input  wire logic [QUERY_W-1:0] i_query_index,
    output logic [SNAP_W-1:0]       o_matrix_state,
    output logic                    o_queried
);

    logic [SNAP_IDX_W-1:0] query_m1;
    logic                  query_hit;

    always_comb begin
        o_matrix_state = '0;
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLUMNS; c++) begin
                if (r * COLUMNS + c < SNAP_W) begin
                    o_matrix_state[r * COLUMNS + c] = i_rows[r][c];
                end
            end
        end
    end

    // Switch numbers start at one; zero and anything past the snapshot report released.
    assign query_hit = (i_query_index != '0) && (i_query_index <= QUERY_W'(SNAP_W));
    assign query_m1  = SNAP_IDX_W'(i_query_index - QUERY_W'(1));
    assign o_queried = query_hit ? o_matrix_state[query_m1] : 1'b0;

endmodule

`default_nettype wire
